@@ hdl/vtq_pkg.sv @@
// Package: shared types and codes for the virtual timer queue.
package vtq_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned MaxResults = 16;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_EXPIRY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] duration_us;
      logic        periodic;
      logic [7:0]  owner_process;
      logic        callback_kind;
      logic [7:0]  callback_handle;
      logic [31:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        fired;
      logic [31:0] timer_ref;
      logic [7:0]  fired_process;
      logic        fired_kind;
      logic [7:0]  fired_handle;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, start a scan
      logic scan_step;  // examine one slot
      logic apply;      // commit the operation found by the scan
      logic emit_done;  // result taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // current slot is the last one
      logic has_result; // operation produces a result
      logic look;       // tick: search for a further due slot before emitting
      logic held;       // tick: a report waits for the outcome of the search
      logic more;       // tick: another due slot was found, commit it next
   } sts_type;

endpackage

@@ hdl/vtq_if.sv @@
// Interfaces: valid/ready channels for requests and responses.
interface vtq_req_if;
   import vtq_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vtq_rsp_if;
   import vtq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/virtual_timer_queue.sv @@
// Top level: virtual timer queue with controller and datapath.
//
//  channel | dir | handshake           | payload
//  req     | in  | req.valid/req.ready | func, duration, periodic, owner, callback, cancel id
//  rsp     | out | rsp.valid/rsp.ready | status, fired, timer ref, expiry info, last
//
// Each scan pass visits one slot per cycle. A start or cancel runs a scan
// pass, a commit and one result; a tick with nothing due, or an unused code,
// runs a scan pass and a commit and gives no result.
// A tick with k reports runs a further search pass after each report, but
// not after the last one when k reaches the 16-report cap (no final search).
// Reset clears the counters and the used bits; slot contents stay undefined.
// A stalled response holds the block in its emit state and the input waits.
module virtual_timer_queue #(
   parameter int unsigned TIMER_SLOTS = 16
) (
   input logic  clock,
   input logic  reset,
   vtq_req_if.sink   req,
   vtq_rsp_if.source rsp
);
   import vtq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Accept one item in idle, scan, commit, then offer each result in turn.
   vtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Result payload comes from the registered result in the datapath, with a tick's
   // last flag from the search; it holds steady for as long as the controller offers it.
   vtq_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req.data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp.data)
   );
endmodule

@@ hdl/vtq_ctrl.sv @@
// Controller: sequences scan, commit and result hand-off.
module vtq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  vtq_pkg::sts_type sts,
   output vtq_pkg::cmd_type cmd
);
   import vtq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = sts.held ? ST_EMIT : ST_APPLY;
         end
         ST_APPLY: begin
            if (!sts.has_result) state_in = ST_IDLE;
            else if (sts.look)   state_in = ST_SCAN;
            else                 state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) state_in = sts.more ? ST_APPLY : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_done = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end
endmodule

@@ hdl/vtq_datapath.sv @@
// Datapath: slot table, counters, serial slot scan and result register.
module vtq_datapath #(
   parameter int unsigned TIMER_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  vtq_pkg::req_type req_data,
   input  vtq_pkg::cmd_type cmd,
   output vtq_pkg::sts_type sts,
   output vtq_pkg::rsp_type rsp_data
);
   import vtq_pkg::*;

   localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);
   localparam logic [CntW-1:0] MaxRes =
      CntW'(MaxResults < TIMER_SLOTS ? MaxResults : TIMER_SLOTS);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

   logic [31:0] expiry_mem [TIMER_SLOTS];
   logic [31:0] period_mem [TIMER_SLOTS];
   logic [31:0] ident_mem  [TIMER_SLOTS];
   logic [7:0]  owner_mem  [TIMER_SLOTS];
   logic [8:0]  cb_mem     [TIMER_SLOTS];
   logic        repeat_mem [TIMER_SLOTS];

   logic [TIMER_SLOTS-1:0] used_ff, done_ff;
   logic [31:0]   now_ff, start_ff;
   req_type       req_ff;
   logic [IdxW-1:0] idx_ff;
   logic          found_ff;
   logic [IdxW-1:0] best_ff;
   logic [31:0]   best_exp_ff;
   logic          free_found_ff;
   logic [IdxW-1:0] free_ff;
   logic [CntW-1:0] nres_ff;
   rsp_type       rsp_ff;
   logic          held_ff;

   logic [31:0] dur;
   logic [31:0] new_start;
   logic [31:0] cur_exp;
   logic        cand;
   logic        is_tick;
   rsp_type     rsp_in;

   assign dur       = (req_ff.duration_us == 32'd0) ? 32'd1 : req_ff.duration_us;
   assign new_start = start_ff + 32'd1;
   assign cur_exp   = expiry_mem[idx_ff];
   assign is_tick   = (req_ff.func == FUNC_TICK);

   // candidate test for the slot under the scan pointer
   always_comb begin
      cand = 1'b0;
      case (func_type'(req_ff.func))
         FUNC_TICK:   cand = used_ff[idx_ff] && !done_ff[idx_ff] && (cur_exp <= now_ff);
         FUNC_CANCEL: cand = used_ff[idx_ff] && (ident_mem[idx_ff] == req_ff.cancel_id);
         default:     cand = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         now_ff   <= '0;
         start_ff <= '0;
      end else if (cmd.load) begin
         if (req_data.func == FUNC_TICK) now_ff <= now_ff + 32'd1;
      end else if (cmd.apply) begin
         case (func_type'(req_ff.func))
            FUNC_TICK: begin
               if (found_ff && !repeat_mem[best_ff]) used_ff[best_ff] <= 1'b0;
            end
            FUNC_START: begin
               start_ff <= new_start;
               if (free_found_ff) used_ff[free_ff] <= 1'b1;
            end
            FUNC_CANCEL: begin
               if (found_ff) used_ff[best_ff] <= 1'b0;
            end
            default: begin
               start_ff <= start_ff;
            end
         endcase
      end
   end

   // table writes: start fills a slot, tick reloads a periodic one
   always_ff @(posedge clock) begin
      if (cmd.apply && req_ff.func == FUNC_START && free_found_ff) begin
         expiry_mem[free_ff] <= now_ff + dur;
         period_mem[free_ff] <= dur;
         ident_mem[free_ff]  <= now_ff + new_start;
         owner_mem[free_ff]  <= req_ff.owner_process;
         cb_mem[free_ff]     <= {req_ff.callback_kind, req_ff.callback_handle};
         repeat_mem[free_ff] <= req_ff.periodic;
      end else if (cmd.apply && is_tick && found_ff && repeat_mem[best_ff]) begin
         expiry_mem[best_ff] <= expiry_mem[best_ff] + period_mem[best_ff];
      end
   end

   // result built from the scan outcome
   always_comb begin
      rsp_in = '0;
      case (func_type'(req_ff.func))
         FUNC_TICK: begin
            rsp_in.status        = STAT_EXPIRY;
            rsp_in.fired         = 1'b1;
            rsp_in.timer_ref     = ident_mem[best_ff];
            rsp_in.fired_process = owner_mem[best_ff];
            rsp_in.fired_kind    = cb_mem[best_ff][8];
            rsp_in.fired_handle  = cb_mem[best_ff][7:0];
         end
         FUNC_START: begin
            rsp_in.status    = free_found_ff ? STAT_OK : STAT_FULL;
            rsp_in.timer_ref = free_found_ff ? now_ff + new_start : 32'd0;
            rsp_in.last      = 1'b1;
         end
         FUNC_CANCEL: begin
            rsp_in.status    = found_ff ? STAT_OK : STAT_NOTFOUND;
            rsp_in.timer_ref = req_ff.cancel_id;
            rsp_in.last      = 1'b1;
         end
         default: begin
            rsp_in.last = 1'b1;
         end
      endcase
   end

   // serial scan state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         done_ff <= '0;
         nres_ff <= '0;
         held_ff <= 1'b0;
      end
      if (cmd.emit_done) held_ff <= 1'b0;
      if (cmd.load || cmd.apply) begin
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (idx_ff != LastIdx) idx_ff <= idx_ff + IdxW'(1);
         if (cand && (!found_ff || cur_exp < best_exp_ff)) begin
            found_ff    <= 1'b1;
            best_ff     <= idx_ff;
            best_exp_ff <= cur_exp;
         end
         if (!used_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_ff       <= idx_ff;
         end
      end
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
         if (is_tick && found_ff) begin
            done_ff[best_ff] <= 1'b1;
            nres_ff          <= nres_ff + CntW'(1);
            held_ff          <= 1'b1;
         end
      end
   end

   // A tick report is held while the next pass searches for another due slot;
   // it is the last one when that pass finds nothing or the report cap is hit.
   assign sts.scan_last  = (idx_ff == LastIdx);
   assign sts.has_result = is_tick ? found_ff
                                   : (req_ff.func == FUNC_START || req_ff.func == FUNC_CANCEL);
   assign sts.look       = is_tick && found_ff && (nres_ff + CntW'(1) != MaxRes);
   assign sts.held       = held_ff;
   assign sts.more       = is_tick && found_ff;

   always_comb begin
      rsp_data = rsp_ff;
      if (is_tick) rsp_data.last = !found_ff;
   end
endmodule
